[design/dbe_pkg.sv]
package dbe_pkg;

    localparam int MAX_DELIM_LEN = 8;
    localparam int CNT_W = $clog2(MAX_DELIM_LEN);
    localparam int LEN_W = 4;
    localparam int DELIM_W = 8 * MAX_DELIM_LEN;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] NEWLINE = 8'h0A;
    // three backticks, first character lowest
    localparam logic [DELIM_W-1:0] DELIM_RESET = 64'h0000_0000_0060_6060;
    localparam logic [LEN_W-1:0] LEN_RESET = 4'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_DELIM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_DELIM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LEN = 3'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
    } dbe_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } dbe_out_t;

    typedef enum logic [1:0] {
        SRC_INPUT  = 2'd0,
        SRC_REPLAY = 2'd1,
        SRC_HELD   = 2'd2
    } dbe_src_t;

    typedef struct packed {
        logic     accept;
        logic     start_replay;
        logic     replay_step;
        logic     out_load;
        dbe_src_t out_src;
        logic     out_last;
    } dbe_cmd_t;

    typedef struct packed {
        logic out_valid;
        logic emits_byte;
        logic needs_replay;
        logic replay_last;
    } dbe_stat_t;

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] n;
        n = raw;
        if (n == '0) begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(MAX_DELIM_LEN)) begin
            n = LEN_W'(MAX_DELIM_LEN);
        end
        return n;
    endfunction

    function automatic logic [7:0] delim_byte(input logic [DELIM_W-1:0] d,
                                              input logic [CNT_W-1:0] idx);
        return d[8*idx +: 8];
    endfunction

endpackage

[design/dbe_datapath.sv]
module dbe_datapath
    import dbe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dbe_in_t              s_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  dbe_cmd_t             cmd,
    output dbe_stat_t            stat,
    input  logic                 m_ready,
    output logic                 m_valid,
    output dbe_out_t             m_data
);

    logic [DELIM_W-1:0] begin_delim_reg;
    logic [LEN_W-1:0]   begin_len_reg;
    logic [DELIM_W-1:0] end_delim_reg;
    logic [LEN_W-1:0]   end_len_reg;

    logic             inside_reg, inside_next;
    logic             line_start_reg, line_start_next;
    logic             eliding_reg, eliding_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [CNT_W-1:0] replay_idx_reg;
    logic [CNT_W-1:0] replay_cnt_reg;
    logic [7:0]       held_reg;
    logic             out_valid_reg, out_valid_next;
    dbe_out_t         out_reg;

    logic [DELIM_W-1:0] cur_delim;
    logic [LEN_W-1:0]   cur_len;
    logic [LEN_W-1:0]   count_inc;
    logic               hit;
    logic               is_nl;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            begin_delim_reg <= DELIM_RESET;
            begin_len_reg   <= LEN_RESET;
            end_delim_reg   <= DELIM_RESET;
            end_len_reg     <= LEN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BEGIN_DELIM: begin_delim_reg <= cfg_data;
                CFG_BEGIN_LEN:   begin_len_reg <= cfg_data[LEN_W-1:0];
                CFG_END_DELIM:   end_delim_reg <= cfg_data;
                CFG_END_LEN:     end_len_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // matcher
    always_comb begin
        cur_delim = inside_reg ? end_delim_reg : begin_delim_reg;
        cur_len   = eff_len(inside_reg ? end_len_reg : begin_len_reg);
        hit       = (delim_byte(cur_delim, count_reg) == s_data.text_byte);
        is_nl     = (s_data.text_byte == NEWLINE);
        count_inc = {1'b0, count_reg} + LEN_W'(1);

        inside_next     = inside_reg;
        line_start_next = line_start_reg;
        eliding_next    = eliding_reg;
        count_next      = count_reg;

        if (s_data.kind) begin
            inside_next     = 1'b0;
            line_start_next = 1'b1;
            eliding_next    = 1'b0;
            count_next      = '0;
        end else if (eliding_reg) begin
            line_start_next = is_nl;
            eliding_next    = !is_nl;
        end else if (line_start_reg && hit) begin
            if (count_inc >= cur_len) begin
                inside_next     = !inside_reg;
                count_next      = '0;
                eliding_next    = 1'b1;
                line_start_next = 1'b0;
            end else begin
                count_next = count_inc[CNT_W-1:0];
            end
        end else begin
            count_next      = '0;
            line_start_next = is_nl;
        end

        stat.emits_byte   = !s_data.kind && !eliding_reg && !(line_start_reg && hit)
                            && inside_reg;
        stat.needs_replay = stat.emits_byte && line_start_reg && (count_reg != '0);
        stat.replay_last  = (replay_idx_reg == replay_cnt_reg - CNT_W'(1));
        stat.out_valid    = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg     <= 1'b0;
            line_start_reg <= 1'b1;
            eliding_reg    <= 1'b0;
            count_reg      <= '0;
        end else if (cmd.accept) begin
            inside_reg     <= inside_next;
            line_start_reg <= line_start_next;
            eliding_reg    <= eliding_next;
            count_reg      <= count_next;
        end
    end

    // replay of a failed end prefix
    always_ff @(posedge aclk) begin
        if (cmd.start_replay) begin
            replay_idx_reg <= '0;
            replay_cnt_reg <= count_reg;
            held_reg       <= s_data.text_byte;
        end else if (cmd.replay_step) begin
            replay_idx_reg <= replay_idx_reg + CNT_W'(1);
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.out_src)
                SRC_REPLAY: out_reg.out_byte <= delim_byte(end_delim_reg, replay_idx_reg);
                SRC_HELD:   out_reg.out_byte <= held_reg;
                default:    out_reg.out_byte <= s_data.text_byte;
            endcase
            out_reg.last_of_run <= cmd.out_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[design/dbe_controller.sv]
module dbe_controller
    import dbe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      m_ready,
    input  dbe_stat_t stat,
    output dbe_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REPLAY = 3'b010,
        ST_EMIT   = 3'b100
    } dbe_state_t;

    dbe_state_t state_reg, state_next;
    logic       out_free;

    assign out_free = !stat.out_valid || m_ready;

    always_comb begin
        state_next       = state_reg;
        s_ready          = 1'b0;
        cmd.accept       = 1'b0;
        cmd.start_replay = 1'b0;
        cmd.replay_step  = 1'b0;
        cmd.out_load     = 1'b0;
        cmd.out_src      = SRC_INPUT;
        cmd.out_last     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = out_free;
                cmd.accept = s_valid && out_free;
                if (cmd.accept) begin
                    if (stat.needs_replay) begin
                        cmd.start_replay = 1'b1;
                        state_next       = ST_REPLAY;
                    end else if (stat.emits_byte) begin
                        cmd.out_load = 1'b1;
                        cmd.out_last = 1'b1;
                    end
                end
            end
            ST_REPLAY: begin
                if (out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_src     = SRC_REPLAY;
                    cmd.replay_step = 1'b1;
                    if (stat.replay_last) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_HELD;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_load_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!stat.out_valid || m_ready))
        else $error("output register overwritten while full");

    a_replay_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_replay |=> !s_ready)
        else $error("input taken during prefix replay");

    a_replay_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.needs_replay |-> stat.emits_byte)
        else $error("replay requested for a byte that is not passed on");

    a_emit_after_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPLAY && out_free && stat.replay_last) |=> state_reg == ST_EMIT)
        else $error("held byte not emitted after replay");

endmodule

[design/delimited_block_extractor_top.sv]
// Delimited block extractor: passes on only the text bytes that lie between a begin and an end
// delimiter, each counted only where it starts a line; the delimiter line itself, through its
// newline, is dropped. An input word with kind set marks end of file and clears the match state
// (not the registers). Delimiters and their lengths are written through the cfg port (index 0
// begin delimiter, 1 begin length, 2 end delimiter, 3 end length); the user must write them
// only while the block is idle, which the block itself does not enforce; cfg_ready is always
// high. One input word is taken per cycle while no prefix replay is under way and the single
// output register is empty or being read, so a result that waits on the receiver holds off
// input. A text word gives at most one output word unless it breaks a partial end match: then,
// inside a block, the matched prefix (1 to 7 words) is replayed from the end delimiter register
// before the failing byte, and input stays held off while the replay sequencer loads the prefix
// words and then the held failing byte into the output register, and while the receiver stalls.
module delimited_block_extractor_top
    import dbe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dbe_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dbe_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    dbe_cmd_t  cmd;
    dbe_stat_t stat;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencing of accepts, replay and output loads
    dbe_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // registers, line state, matcher and output word
    dbe_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
